// File: src/obpbtb_pkg.sv
// Package for the one-bit branch predictor with branch target buffer.
// Holds the controller state type and the fixed address constants.
// No dependencies.
package obpbtb_pkg;

    // Clears the two low bits of a pc before the table lookup.
    localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFC;

    // Fall-through distance of a branch that is not in the table.
    localparam logic [31:0] PC_STEP = 32'd4;

    // Width of a branch target as held in the table.
    localparam int TARGET_BITS = 32;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

// File: src/one_bit_branch_predictor_btb.sv
// Top level of the one-bit branch predictor with branch target buffer.
// Depends on obpbtb_pkg and obpbtb_ram.
//
// Usage
// -----
// One input channel in command style: an item transfers at a rising edge
// where i_start is high and o_busy is low. i_mode selects a prediction
// request (0) or a resolved-branch update (1); i_branch_target and
// i_outcome_taken matter for updates only.
//
// Each item yields exactly one result. The result ports carry it for one
// cycle, marked by o_valid, and the transfer completes at the edge that
// ends that cycle. The receiver cannot stall; it must take each result.
//
// An accepted item's result is registered at the end of the lookup state,
// and o_busy is high until then, so no new item is taken before the last
// one's result is formed. The table lives in a synchronous memory with one
// read port and one write port: the entry is read as the item is accepted,
// then the lookup state forms the prediction, updates the counters and, for
// an update, writes the entry back. As the write lands before the next read,
// successive items on one entry see each other's updates without forwarding.
//
// Reset (i_rst_n low, synchronous) zeroes the three counters and starts a
// clearing pass that writes an invalid entry into each of the 2**INDEX_BITS
// table rows, one row per cycle. o_busy stays high during the pass.
module one_bit_branch_predictor_btb #(
    parameter int INDEX_BITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_mode,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_branch_target,
    input  logic        i_outcome_taken,

    output logic        o_valid,
    output logic        o_predict_taken,
    output logic [31:0] o_predict_target,
    output logic        o_entry_hit,
    output logic        o_was_correct,
    output logic [31:0] o_request_count,
    output logic [31:0] o_correct_count,
    output logic [31:0] o_mispredict_count
);

    // The tag is whatever of the aligned pc lies above the index.
    localparam int TAG_BITS   = 30 - INDEX_BITS;
    localparam int TGT_BITS   = obpbtb_pkg::TARGET_BITS;
    // Entry layout, high to low: valid, tag, taken, target.
    localparam int ENTRY_BITS = 1 + TAG_BITS + 1 + TGT_BITS;

    obpbtb_pkg::t_state r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_idx, n_clr_idx;

    // Captured item.
    logic                  r_mode;
    logic [31:0]           r_pc;
    logic [31:0]           r_tgt;
    logic                  r_taken;
    logic [INDEX_BITS-1:0] r_idx;
    logic [TAG_BITS-1:0]   r_tag;

    // Counters and result registers.
    logic [31:0] r_req_cnt, n_req_cnt;
    logic [31:0] r_ok_cnt, n_ok_cnt;
    logic [31:0] r_bad_cnt, n_bad_cnt;
    logic        r_valid, n_valid;
    logic        r_pred, n_pred;
    logic [31:0] r_ptgt, n_ptgt;
    logic        r_hit, n_hit;
    logic        r_correct, n_correct;

    // Memory ports.
    logic                  mem_we;
    logic [INDEX_BITS-1:0] mem_waddr;
    logic [ENTRY_BITS-1:0] mem_wdata;
    logic [INDEX_BITS-1:0] mem_raddr;
    logic [ENTRY_BITS-1:0] mem_rdata;

    logic [31:0]           in_aligned;
    logic                  accept;
    logic                  ent_valid;
    logic [TAG_BITS-1:0]   ent_tag;
    logic                  ent_taken;
    logic [TGT_BITS-1:0]   ent_target;

    assign in_aligned = i_pc & obpbtb_pkg::ALIGN_MASK;
    assign accept     = i_start && (r_state == obpbtb_pkg::ST_IDLE);
    assign mem_raddr  = in_aligned[INDEX_BITS+1:2];

    assign ent_valid  = mem_rdata[ENTRY_BITS-1];
    assign ent_tag    = mem_rdata[ENTRY_BITS-2 -: TAG_BITS];
    assign ent_taken  = mem_rdata[TGT_BITS];
    assign ent_target = mem_rdata[TGT_BITS-1:0];

    obpbtb_ram #(
        .ADDR_BITS (INDEX_BITS),
        .DATA_BITS (ENTRY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Next state, counters, result and write-back.
    always_comb begin
        logic hit;
        logic pred;
        hit = ent_valid && (ent_tag == r_tag);
        pred = hit && ent_taken;

        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_req_cnt = r_req_cnt;
        n_ok_cnt  = r_ok_cnt;
        n_bad_cnt = r_bad_cnt;
        n_valid   = 1'b0;
        n_pred    = r_pred;
        n_ptgt    = r_ptgt;
        n_hit     = r_hit;
        n_correct = r_correct;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = {1'b1, r_tag, r_taken, r_tgt};

        case (r_state)
            obpbtb_pkg::ST_CLEAR: begin
                // Write an invalid entry; the other fields do not matter.
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == {INDEX_BITS{1'b1}}) begin
                    n_state = obpbtb_pkg::ST_IDLE;
                end
            end
            obpbtb_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = obpbtb_pkg::ST_LOOKUP;
                end
            end
            obpbtb_pkg::ST_LOOKUP: begin
                n_valid   = 1'b1;
                n_pred    = pred;
                n_hit     = hit;
                n_ptgt    = hit ? ent_target : (r_pc + obpbtb_pkg::PC_STEP);
                n_correct = 1'b0;
                if (r_mode) begin
                    mem_we = 1'b1;
                    if (pred == r_taken) begin
                        n_correct = 1'b1;
                        n_ok_cnt  = r_ok_cnt + 32'd1;
                    end else begin
                        n_bad_cnt = r_bad_cnt + 32'd1;
                    end
                end else begin
                    n_req_cnt = r_req_cnt + 32'd1;
                end
                n_state = obpbtb_pkg::ST_IDLE;
            end
            default: begin
                n_state = obpbtb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= obpbtb_pkg::ST_CLEAR;
            r_clr_idx <= '0;
            r_req_cnt <= '0;
            r_ok_cnt  <= '0;
            r_bad_cnt <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_req_cnt <= n_req_cnt;
            r_ok_cnt  <= n_ok_cnt;
            r_bad_cnt <= n_bad_cnt;
            r_valid   <= n_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_pc    <= i_pc;
            r_tgt   <= i_branch_target;
            r_taken <= i_outcome_taken;
            r_idx   <= in_aligned[INDEX_BITS+1:2];
            r_tag   <= in_aligned[31:INDEX_BITS+2];
        end
        r_pred    <= n_pred;
        r_ptgt    <= n_ptgt;
        r_hit     <= n_hit;
        r_correct <= n_correct;
    end

    assign o_busy             = (r_state != obpbtb_pkg::ST_IDLE);
    assign o_valid            = r_valid;
    assign o_predict_taken    = r_pred;
    assign o_predict_target   = r_ptgt;
    assign o_entry_hit        = r_hit;
    assign o_was_correct      = r_correct;
    assign o_request_count    = r_req_cnt;
    assign o_correct_count    = r_ok_cnt;
    assign o_mispredict_count = r_bad_cnt;

endmodule

// File: src/obpbtb_ram.sv
// Single-port-write, single-port-read synchronous memory for the table.
// Read data is registered, so it appears in the cycle after the address.
// No package dependency.
module obpbtb_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 58
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/obpbtb_checker.sv
// Port-level checker for the one-bit branch predictor with branch target buffer.
// Depends only on the top level's ports; bound to it at the end of this file.
module obpbtb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid,
    input logic o_predict_taken,
    input logic o_entry_hit
);

    // A transfer makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after an input transfer");

    // Every transfer gives its result.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_valid)
        else $error("result missing two cycles after an input transfer");

    // The strobe lasts one cycle.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // A result appears only while the block is ready for the next item.
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("block busy while a result is shown");

    // A table miss always predicts not taken.
    a_miss_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_entry_hit) |-> !o_predict_taken)
        else $error("taken prediction reported on a miss");

endmodule

bind one_bit_branch_predictor_btb obpbtb_checker u_obpbtb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_valid         (o_valid),
    .o_predict_taken (o_predict_taken),
    .o_entry_hit     (o_entry_hit)
);
